>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SBR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbr assertion failed");

// next-cycle implication, off while reset is asserted
`define SBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbr assertion failed");

`endif

>>> rtl/sbr_pkg.sv
`default_nettype none
package sbr_pkg;

    localparam int FrameLen       = 25;
    localparam int HeldW          = 5;
    localparam int FrameDataBytes = 22;
    localparam int FlagPos        = 23;
    localparam int LostBit        = 2;
    localparam int FailsafeBit    = 3;
    localparam int NumCh          = 16;
    localparam int ChW            = 4;
    localparam int RawW           = 11;
    localparam int ScaledW        = 8;
    localparam int FrameNumW      = 32;

    localparam logic [7:0] HeaderByte = 8'h0F;
    localparam logic [7:0] EndByte    = 8'h00;

    // (raw - 1024) * 100 / 671 on the magnitude:
    // floor(mag * 100 * ceil(2^27 / 671) / 2^27) is exact for mag <= 1024
    localparam int RawMid     = 1024;
    localparam int MagW       = 11;
    localparam int ScaleKW    = 25;
    localparam int ScaleK     = 20002700;
    localparam int ScaleShift = 27;
    localparam int QuotW      = 8;
    localparam int ScaleMax   = 100;
    localparam int DeadBand   = 5;

    localparam int QueueDepthDef = 2;

    typedef struct packed {
        logic [FrameDataBytes*8-1:0] data;
        logic                        lost;
        logic                        failsafe;
        logic [FrameNumW-1:0]        frame_number;
    } frame_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_RESYNC  = 2'b10
    } front_state_t;

endpackage
`default_nettype wire

>>> rtl/sbr_if.sv
`default_nettype none
interface sbr_rx_if import sbr_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbr_res_if import sbr_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [ChW-1:0]             channel_index;
    logic [RawW-1:0]            raw_value;
    logic signed [ScaledW-1:0]  scaled_value;
    logic                       link_lost;
    logic                       failsafe_active;
    logic [FrameNumW-1:0]       frame_number;
    logic                       last_of_frame;

    modport source (
        output valid, input ready, output channel_index, output raw_value,
        output scaled_value, output link_lost, output failsafe_active,
        output frame_number, output last_of_frame
    );
    modport sink (
        input valid, output ready, input channel_index, input raw_value,
        input scaled_value, input link_lost, input failsafe_active,
        input frame_number, input last_of_frame
    );
endinterface
`default_nettype wire

>>> rtl/sbus_frame_receiver.sv
// channel  | dir | payload                                          | accepted when
// ---------+-----+--------------------------------------------------+--------------
// rx       | in  | rx_byte                                          | valid && ready
// result   | out | channel_index, raw_value, scaled_value,          | valid && ready
//          |     | link_lost, failsafe_active, frame_number,        |
//          |     | last_of_frame                                    |
//
// one byte per cycle while collecting and the frame queue has room; a bad end byte
// starts a resync (one buffer shift per cycle) with rx.ready low
// a good frame goes to a frame queue; the back end gives one channel per cycle
// while result is not stalled, 16 channels per frame, via s1, s2 and out registers
// rx.ready also drops while the frame queue is full
// rst_n is asynchronous: clears byte count, frame count, queue and pipeline valids
`default_nettype none
module sbus_frame_receiver import sbr_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDef
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbr_rx_if.sink      rx,
    sbr_res_if.source   result
);

    frame_t push_data;
    logic   push_valid;
    logic   push_ready;
    frame_t pop_data;
    logic   pop_valid;
    logic   pop_ready;

    sbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    sbr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    sbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
`default_nettype wire

>>> rtl/sbr_front.sv
`default_nettype none
module sbr_front import sbr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbr_rx_if.sink      rx,
    output frame_t      push_data,
    output logic        push_valid,
    input  wire logic   push_ready
);

    logic [7:0]           fbuf_reg [FrameLen];
    logic [HeldW-1:0]     held_reg, held_next;
    logic [FrameNumW-1:0] frames_reg, frames_next;
    front_state_t         state_reg, state_next;

    logic accept;
    logic store;
    logic is_full;
    logic frame_ok;
    logic in_resync;

    assign in_resync = (state_reg == ST_RESYNC);
    assign rx.ready  = (state_reg == ST_COLLECT) && push_ready;
    assign accept    = rx.valid && rx.ready;
    // an empty buffer only takes a header
    assign store     = accept && ((held_reg != '0) || (rx.rx_byte == HeaderByte));
    assign is_full   = (held_reg == HeldW'(FrameLen - 1));
    assign frame_ok  = (fbuf_reg[0] == HeaderByte) && (rx.rx_byte == EndByte);
    assign push_valid = store && is_full && frame_ok;

    always_comb
    begin
        push_data = '0;
        for (int k = 0; k < FrameDataBytes; k++)
        begin
            push_data.data[k*8 +: 8] = fbuf_reg[k+1];
        end
        push_data.lost         = fbuf_reg[FlagPos][LostBit];
        push_data.failsafe     = fbuf_reg[FlagPos][FailsafeBit];
        push_data.frame_number = frames_reg + FrameNumW'(1);
    end

    always_comb
    begin
        held_next   = held_reg;
        frames_next = frames_reg;
        state_next  = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (store)
                begin
                    if (!is_full)
                    begin
                        held_next = held_reg + HeldW'(1);
                    end
                    else if (frame_ok)
                    begin
                        held_next   = '0;
                        frames_next = frames_reg + FrameNumW'(1);
                    end
                    else
                    begin
                        // all 25 held, drop from the front until a header leads
                        held_next  = HeldW'(FrameLen);
                        state_next = ST_RESYNC;
                    end
                end
            end
            ST_RESYNC:
            begin
                held_next = held_reg - HeldW'(1);
                if ((fbuf_reg[1] == HeaderByte) || (held_reg == HeldW'(1)))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                held_next  = '0;
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            frames_reg <= '0;
            state_reg  <= ST_COLLECT;
        end
        else
        begin
            held_reg   <= held_next;
            frames_reg <= frames_next;
            state_reg  <= state_next;
        end
    end

    for (genvar i = 0; i < FrameLen; i++)
    begin : g_buf
        if (i < FrameLen - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (in_resync)
                begin
                    fbuf_reg[i] <= fbuf_reg[i+1];
                end
                else if (store && (held_reg == HeldW'(i)))
                begin
                    fbuf_reg[i] <= rx.rx_byte;
                end
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk)
            begin
                if (!in_resync && store && (held_reg == HeldW'(i)))
                begin
                    fbuf_reg[i] <= rx.rx_byte;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/sbr_queue.sv
`default_nettype none
module sbr_queue import sbr_pkg::*;
#(
    parameter int Depth = QueueDepthDef
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire frame_t push_data,
    input  wire logic   push_valid,
    output logic        push_ready,
    output frame_t      pop_data,
    output logic        pop_valid,
    input  wire logic   pop_ready
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    frame_t          mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sbr_back.sv
`default_nettype none
module sbr_back import sbr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire frame_t pop_data,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    sbr_res_if.source   result
);

    typedef struct packed {
        logic [ChW-1:0]       ch;
        logic [RawW-1:0]      raw;
        logic                 neg;
        logic [MagW-1:0]      mag;
        logic                 lost;
        logic                 failsafe;
        logic [FrameNumW-1:0] frame_number;
        logic                 last;
    } chan_t;

    localparam int ProdW = MagW + ScaleKW;
    localparam int IdxW  = $clog2(FrameDataBytes * 8);

    logic [ChW-1:0] ch_reg, ch_next;
    logic           s1_valid_reg, s2_valid_reg, out_valid_reg;
    chan_t          s1_reg, s2_reg;
    logic [QuotW-1:0] s2_q_reg;

    logic [ChW-1:0]            out_ch_reg;
    logic [RawW-1:0]           out_raw_reg;
    logic signed [ScaledW-1:0] out_scaled_reg;
    logic                      out_lost_reg;
    logic                      out_fs_reg;
    logic [FrameNumW-1:0]      out_fnum_reg;
    logic                      out_last_reg;

    logic        en;
    logic        is_last_ch;
    logic [IdxW-1:0] bit_idx;
    chan_t       issue;
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] q_clamp;
    logic [QuotW-1:0] q_dead;
    logic signed [ScaledW-1:0] scaled;

    // whole pipeline moves when the output register is free or being taken
    assign en         = !out_valid_reg || result.ready;
    assign is_last_ch = (ch_reg == ChW'(NumCh - 1));
    assign pop_ready  = en && is_last_ch;
    assign ch_next    = is_last_ch ? '0 : ch_reg + ChW'(1);
    assign bit_idx    = IdxW'(ch_reg) * IdxW'(RawW);

    always_comb
    begin
        issue.ch           = ch_reg;
        issue.raw          = pop_data.data[bit_idx +: RawW];
        issue.neg          = !issue.raw[RawW-1];
        issue.mag          = issue.raw[RawW-1] ? (issue.raw - RawW'(RawMid))
                                               : (RawW'(RawMid) - issue.raw);
        issue.lost         = pop_data.lost;
        issue.failsafe     = pop_data.failsafe;
        issue.frame_number = pop_data.frame_number;
        issue.last         = is_last_ch;
    end

    assign prod = ProdW'(s1_reg.mag) * ProdW'(ScaleK);

    always_comb
    begin
        q_clamp = (s2_q_reg > QuotW'(ScaleMax)) ? QuotW'(ScaleMax) : s2_q_reg;
        q_dead  = (q_clamp < QuotW'(DeadBand)) ? '0 : q_clamp;
        scaled  = s2_reg.neg ? -$signed(ScaledW'(q_dead)) : $signed(ScaledW'(q_dead));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (pop_valid)
            begin
                ch_reg <= ch_next;
            end
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg         <= issue;
            s2_reg         <= s1_reg;
            s2_q_reg       <= prod[ScaleShift +: QuotW];
            out_ch_reg     <= s2_reg.ch;
            out_raw_reg    <= s2_reg.raw;
            out_scaled_reg <= scaled;
            out_lost_reg   <= s2_reg.lost;
            out_fs_reg     <= s2_reg.failsafe;
            out_fnum_reg   <= s2_reg.frame_number;
            out_last_reg   <= s2_reg.last;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.channel_index   = out_ch_reg;
    assign result.raw_value       = out_raw_reg;
    assign result.scaled_value    = out_scaled_reg;
    assign result.link_lost       = out_lost_reg;
    assign result.failsafe_active = out_fs_reg;
    assign result.frame_number    = out_fnum_reg;
    assign result.last_of_frame   = out_last_reg;

endmodule
`default_nettype wire

>>> rtl/sbr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sbr_checker import sbr_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       res_valid,
    input wire logic                       res_ready,
    input wire logic [ChW-1:0]             res_channel_index,
    input wire logic [RawW-1:0]            res_raw_value,
    input wire logic signed [ScaledW-1:0]  res_scaled_value,
    input wire logic                       res_last_of_frame
);

    // a pending item is not withdrawn
    `SBR_ASSERT_NEXT(a_valid_held, clk, rst_n, res_valid && !res_ready, res_valid)

    // frame end marker sits on the top channel only
    `SBR_ASSERT_IMPL(a_last_top_ch, clk, rst_n, res_valid, res_last_of_frame == (res_channel_index == ChW'(NumCh - 1)))

    `SBR_ASSERT_IMPL(a_scaled_range, clk, rst_n, res_valid, (res_scaled_value <= ScaleMax) && (res_scaled_value >= -ScaleMax))

    // nothing survives inside the deadband but zero
    `SBR_ASSERT_IMPL(a_deadband, clk, rst_n, res_valid, (res_scaled_value == 0) || (res_scaled_value >= DeadBand) || (res_scaled_value <= -DeadBand))

    // raw at or above midpoint never scales negative
    `SBR_ASSERT_IMPL(a_sign, clk, rst_n, res_valid && (res_raw_value >= RawW'(RawMid)), res_scaled_value >= 0)

endmodule

bind sbus_frame_receiver sbr_checker u_sbr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_channel_index (result.channel_index),
    .res_raw_value     (result.raw_value),
    .res_scaled_value  (result.scaled_value),
    .res_last_of_frame (result.last_of_frame)
);
`default_nettype wire
